// ===== design/channel_baseline_average_subtract_core_macros.svh =====
// Assertion macros shared by the baseline subtraction core
`ifndef CHANNEL_BASELINE_AVERAGE_SUBTRACT_CORE_MACROS_SVH
`define CHANNEL_BASELINE_AVERAGE_SUBTRACT_CORE_MACROS_SVH

// Same-cycle implication, clocked on clk_i, off while rst_ni is low
`define CBAS_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, clocked on clk_i, off while rst_ni is low
`define CBAS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/cbas_pkg.sv =====
// Shared types and constants of the baseline subtraction core
`default_nettype none

package cbas_pkg;

  localparam int VAL_W     = 32;
  localparam int SUM_W     = 48;
  localparam int CNT_W     = 16;
  localparam int DIV_DIGIT = 2;
  localparam int DIV_STEPS = SUM_W / DIV_DIGIT;

  localparam logic [1:0] MODE_ADD     = 2'd0;
  localparam logic [1:0] MODE_CORRECT = 2'd1;
  localparam logic [1:0] MODE_CLEAR   = 2'd2;

  localparam logic [1:0] PLANE_X   = 2'd0;
  localparam logic [1:0] PLANE_Y   = 2'd1;
  localparam logic [1:0] PLANE_CUP = 2'd2;

  localparam int         CFG_ADDR_W         = 1;
  localparam logic [0:0] REG_CORRECT_ENABLE = 1'b0;
  localparam logic [0:0] REG_MEASURE_MODE   = 1'b1;

  typedef struct packed {
    logic [CNT_W-1:0]        count;
    logic signed [SUM_W-1:0] sum;
    logic signed [VAL_W-1:0] offset;
  } entry_t;

  typedef struct packed {
    logic rd;
    logic wr;
    logic clr;
    logic cup;
  } tbl_ctrl_t;

endpackage

`default_nettype wire

// ===== design/cbas_table.sv =====
// Per-channel count, sum and offset memories for the grid and cup planes
`default_nettype none

module cbas_table #(
  parameter int GRID_DEPTH = 1024,
  parameter int CUP_DEPTH  = 256,
  parameter int ADDR_W     = 11
) (
  input  logic                clk_i,
  input  cbas_pkg::tbl_ctrl_t ctrl_i,
  input  logic [ADDR_W-1:0]   addr_i,
  input  cbas_pkg::entry_t    wdata_i,
  output cbas_pkg::entry_t    rdata_o
);
  import cbas_pkg::*;

  localparam int GRID_MEM = 2 * GRID_DEPTH;
  localparam int GAW      = $clog2(GRID_MEM);
  localparam int CAW      = (CUP_DEPTH > 1) ? $clog2(CUP_DEPTH) : 1;

  entry_t grid_mem [GRID_MEM];
  entry_t cup_mem  [CUP_DEPTH];
  entry_t grid_q;
  entry_t cup_q;
  logic   cup_sel_q;

  logic   grid_we;
  logic   cup_we;
  entry_t wd;

  // X wires sit in the lower half of the grid memory, Y wires in the upper
  always_comb begin
    wd      = ctrl_i.clr ? '0 : wdata_i;
    grid_we = ctrl_i.clr ? (32'(addr_i) < 32'(GRID_MEM)) : (ctrl_i.wr && !ctrl_i.cup);
    cup_we  = ctrl_i.clr ? (32'(addr_i) < 32'(CUP_DEPTH)) : (ctrl_i.wr && ctrl_i.cup);
  end

  always_ff @(posedge clk_i) begin
    if (grid_we) begin
      grid_mem[addr_i[GAW-1:0]] <= wd;
    end
    if (ctrl_i.rd && !ctrl_i.cup) begin
      grid_q <= grid_mem[addr_i[GAW-1:0]];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cup_we) begin
      cup_mem[addr_i[CAW-1:0]] <= wd;
    end
    if (ctrl_i.rd && ctrl_i.cup) begin
      cup_q <= cup_mem[addr_i[CAW-1:0]];
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.rd) begin
      cup_sel_q <= ctrl_i.cup;
    end
  end

  assign rdata_o = cup_sel_q ? cup_q : grid_q;

endmodule

`default_nettype wire

// ===== design/cbas_div.sv =====
// Digit-serial signed mean divider: sum over count, two quotient bits a cycle
`default_nettype none
`include "channel_baseline_average_subtract_core_macros.svh"

module cbas_div (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  start_i,
  input  logic signed [cbas_pkg::SUM_W-1:0]     sum_i,
  input  logic        [cbas_pkg::CNT_W-1:0]     count_i,
  output logic                                  done_o,
  output logic signed [cbas_pkg::VAL_W-1:0]     quot_o
);
  import cbas_pkg::*;

  localparam int STEP_W = $clog2(DIV_STEPS);

  logic [CNT_W-1:0]  rem_q, rem_d;
  logic [SUM_W-1:0]  dq_q, dq_d;
  logic [CNT_W-1:0]  div_q;
  logic              neg_q;
  logic [STEP_W-1:0] step_q;
  logic              busy_q;
  logic              done_q;
  logic              last_step;
  logic              big;

  // Restoring steps: shift the dividend into the remainder, subtract if it fits
  always_comb begin
    logic [CNT_W:0] r;
    logic           ge;
    rem_d = rem_q;
    dq_d  = dq_q;
    for (int k = 0; k < DIV_DIGIT; k++) begin
      r     = {rem_d, dq_d[SUM_W-1]};
      ge    = (r >= {1'b0, div_q});
      rem_d = ge ? CNT_W'(r - {1'b0, div_q}) : r[CNT_W-1:0];
      dq_d  = {dq_d[SUM_W-2:0], ge};
    end
  end

  assign last_step = (step_q == STEP_W'(DIV_STEPS - 1));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      done_q <= busy_q && last_step;
      if (start_i) begin
        busy_q <= 1'b1;
        step_q <= '0;
      end else if (busy_q) begin
        if (last_step) begin
          busy_q <= 1'b0;
        end
        step_q <= last_step ? '0 : step_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      dq_q  <= sum_i[SUM_W-1] ? SUM_W'(-sum_i) : SUM_W'(sum_i);
      div_q <= count_i;
      neg_q <= sum_i[SUM_W-1];
    end else if (busy_q) begin
      rem_q <= rem_d;
      dq_q  <= dq_d;
    end
  end

  // Clamp the magnitude to the signed 32-bit range, then restore the sign
  assign big = |dq_q[SUM_W-1:VAL_W-1];

  always_comb begin
    if (big) begin
      quot_o = neg_q ? {1'b1, {(VAL_W-1){1'b0}}} : {1'b0, {(VAL_W-1){1'b1}}};
    end else begin
      quot_o = neg_q ? VAL_W'(-dq_q[VAL_W-1:0]) : dq_q[VAL_W-1:0];
    end
  end

  assign done_o = done_q;

  `CBAS_ASSERT_IMP(a_div_start_idle, start_i, !busy_q, "divider started while busy")
  `CBAS_ASSERT_IMP(a_div_done_idle, done_q, !busy_q, "divider done while still busy")
  `CBAS_ASSERT_NEXT(a_div_busy_after_start, start_i, busy_q && step_q == '0,
                    "divider did not begin after start")

endmodule

`default_nettype wire

// ===== design/channel_baseline_average_subtract_core.sv =====
// Top level of the per-channel baseline averaging and subtraction core
//
//   channel  direction  handshake                fields
//   in       request    in_valid_i / in_stall_o   mode, plane, indices, sample_value
//   out      result     out_valid_o / out_stall_i result_value, index_error
//   cfg      write      cfg_wr_en_i               cfg_addr_i, cfg_wdata_i
//
// Add request: index, address, table read, update, divider at 2 quotient bits per cycle
// (24 steps), output. Correct request: index, address, table read, output; out of range:
// index, output. Clear request and reset: clearing pass over max(2*GRID_DEPTH, CUP_DEPTH)
// addresses, GRID_DEPTH = NUM_GRIDS*NUM_LOOPS*NUM_WIRES; in_stall_o stays high throughout.
// One request at a time; the next is taken while the last result waits on out_stall_i.
`default_nettype none
`include "channel_baseline_average_subtract_core_macros.svh"

module channel_baseline_average_subtract_core #(
  parameter int NUM_GRIDS    = 8,
  parameter int NUM_LOOPS    = 4,
  parameter int NUM_WIRES    = 32,
  parameter int NUM_CUPS     = 8,
  parameter int NUM_SEGMENTS = 8
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  cfg_wr_en_i,
  input  logic [cbas_pkg::CFG_ADDR_W-1:0]       cfg_addr_i,
  input  logic [0:0]                            cfg_wdata_i,
  input  logic                                  in_valid_i,
  output logic                                  in_stall_o,
  input  logic [1:0]                            mode_i,
  input  logic [1:0]                            plane_i,
  input  logic [7:0]                            device_index_i,
  input  logic [7:0]                            loop_index_i,
  input  logic [7:0]                            channel_index_i,
  input  logic signed [cbas_pkg::VAL_W-1:0]     sample_value_i,
  output logic                                  out_valid_o,
  input  logic                                  out_stall_i,
  output logic signed [cbas_pkg::VAL_W-1:0]     result_value_o,
  output logic                                  index_error_o
);
  import cbas_pkg::*;

  localparam int GRID_DEPTH = NUM_GRIDS * NUM_LOOPS * NUM_WIRES;
  localparam int CUP_DEPTH  = NUM_CUPS * NUM_LOOPS * NUM_SEGMENTS;
  localparam int CLR_LEN    = (2 * GRID_DEPTH > CUP_DEPTH) ? 2 * GRID_DEPTH : CUP_DEPTH;
  localparam int ADDR_W     = $clog2(CLR_LEN);
  localparam int M_MAX      = (2 * NUM_GRIDS * NUM_LOOPS > NUM_CUPS * NUM_LOOPS) ?
                              2 * NUM_GRIDS * NUM_LOOPS : NUM_CUPS * NUM_LOOPS;
  localparam int M_W        = $clog2(M_MAX);

  typedef enum logic [8:0] {
    S_IDLE = 9'b000000001,
    S_IDX  = 9'b000000010,
    S_ADR  = 9'b000000100,
    S_RD   = 9'b000001000,
    S_RDW  = 9'b000010000,
    S_UPD  = 9'b000100000,
    S_DIV  = 9'b001000000,
    S_OUT  = 9'b010000000,
    S_CLR  = 9'b100000000
  } state_e;

  state_e state_q, state_d;

  logic correct_en_q;
  logic measure_q;

  logic [1:0]              mode_q;
  logic [1:0]              plane_q;
  logic [7:0]              dev_q;
  logic [7:0]              loop_q;
  logic [7:0]              chan_q;
  logic signed [VAL_W-1:0] sample_q;
  logic [M_W-1:0]          m_q, m_d;
  logic [ADDR_W-1:0]       addr_q;
  logic [ADDR_W-1:0]       clr_cnt_q;
  logic                    clr_item_q;
  logic [CNT_W-1:0]        upd_cnt_q;
  logic signed [SUM_W-1:0] upd_sum_q;
  logic signed [VAL_W-1:0] res_q;
  logic                    err_q;
  logic signed [VAL_W-1:0] out_value_q;
  logic                    out_err_q;
  logic                    out_valid_q;

  logic                    in_acc;
  logic                    out_load;
  logic                    clr_last;
  logic                    idx_ok;
  logic                    is_cup;
  logic [CNT_W-1:0]        cnt_n;
  logic signed [SUM_W-1:0] sum_n;
  logic [SUM_W:0]          sum_w;
  logic [VAL_W:0]          diff_w;
  logic signed [VAL_W-1:0] corr;

  tbl_ctrl_t               tbl_ctrl;
  logic [ADDR_W-1:0]       tbl_addr;
  entry_t                  tbl_wdata;
  entry_t                  tbl_rdata;
  logic                    div_done;
  logic signed [VAL_W-1:0] div_quot;

  assign in_stall_o = (state_q != S_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign out_load   = (state_q == S_OUT) && (!out_valid_q || !out_stall_i);
  assign clr_last   = (clr_cnt_q == ADDR_W'(CLR_LEN - 1));
  assign is_cup     = (plane_q == PLANE_CUP);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      correct_en_q <= 1'b1;
      measure_q    <= 1'b0;
    end else if (cfg_wr_en_i) begin
      unique case (cfg_addr_i)
        REG_CORRECT_ENABLE: correct_en_q <= cfg_wdata_i[0];
        REG_MEASURE_MODE:   measure_q    <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  // Range check and first half of the flat index; Y wires offset past the X half
  always_comb begin
    unique case (plane_q)
      PLANE_X, PLANE_Y: idx_ok = (32'(dev_q) < 32'(NUM_GRIDS)) &&
                                 (32'(loop_q) < 32'(NUM_LOOPS)) &&
                                 (32'(chan_q) < 32'(NUM_WIRES));
      PLANE_CUP:        idx_ok = (32'(dev_q) < 32'(NUM_CUPS)) &&
                                 (32'(loop_q) < 32'(NUM_LOOPS)) &&
                                 (32'(chan_q) < 32'(NUM_SEGMENTS));
      default:          idx_ok = 1'b0;
    endcase
    m_d = M_W'(dev_q) * M_W'(NUM_LOOPS) + M_W'(loop_q) +
          ((plane_q == PLANE_Y) ? M_W'(NUM_GRIDS * NUM_LOOPS) : M_W'(0));
  end

  // Saturating count and sum update, saturating correction
  always_comb begin
    cnt_n  = (tbl_rdata.count == {CNT_W{1'b1}}) ? tbl_rdata.count : tbl_rdata.count + 1'b1;
    sum_w  = {tbl_rdata.sum[SUM_W-1], tbl_rdata.sum} +
             {{(SUM_W-VAL_W+1){sample_q[VAL_W-1]}}, sample_q};
    if (sum_w[SUM_W] != sum_w[SUM_W-1]) begin
      sum_n = sum_w[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}} : {1'b0, {(SUM_W-1){1'b1}}};
    end else begin
      sum_n = sum_w[SUM_W-1:0];
    end
    diff_w = {sample_q[VAL_W-1], sample_q} -
             {tbl_rdata.offset[VAL_W-1], tbl_rdata.offset};
    if (diff_w[VAL_W] != diff_w[VAL_W-1]) begin
      corr = diff_w[VAL_W] ? {1'b1, {(VAL_W-1){1'b0}}} : {1'b0, {(VAL_W-1){1'b1}}};
    end else begin
      corr = diff_w[VAL_W-1:0];
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          unique case (mode_i)
            MODE_ADD, MODE_CORRECT: state_d = S_IDX;
            MODE_CLEAR:             state_d = S_CLR;
            default:                state_d = S_OUT;
          endcase
        end
      end
      S_IDX:  state_d = idx_ok ? S_ADR : S_OUT;
      S_ADR:  state_d = S_RD;
      S_RD:   state_d = S_RDW;
      S_RDW:  state_d = (mode_q == MODE_ADD) ? S_UPD : S_OUT;
      S_UPD:  state_d = S_DIV;
      S_DIV: begin
        if (div_done) begin
          state_d = S_OUT;
        end
      end
      S_OUT: begin
        if (out_load) begin
          state_d = S_IDLE;
        end
      end
      S_CLR: begin
        if (clr_last) begin
          state_d = clr_item_q ? S_OUT : S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Reset starts with a clearing pass and no request pending
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLR;
      clr_cnt_q   <= '0;
      clr_item_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == S_CLR) begin
        clr_cnt_q <= clr_last ? '0 : clr_cnt_q + 1'b1;
        if (clr_last) begin
          clr_item_q <= 1'b0;
        end
      end else if (in_acc && mode_i == MODE_CLEAR) begin
        clr_item_q <= 1'b1;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          mode_q   <= mode_i;
          plane_q  <= plane_i;
          dev_q    <= device_index_i;
          loop_q   <= loop_index_i;
          chan_q   <= channel_index_i;
          sample_q <= sample_value_i;
          res_q    <= '0;
          err_q    <= 1'b0;
        end
      end
      S_IDX: begin
        m_q <= m_d;
        if (!idx_ok) begin
          res_q <= (mode_q == MODE_ADD) ? '0 : sample_q;
          err_q <= 1'b1;
        end
      end
      S_ADR: begin
        addr_q <= is_cup ? ADDR_W'(m_q) * ADDR_W'(NUM_SEGMENTS) + ADDR_W'(chan_q)
                         : ADDR_W'(m_q) * ADDR_W'(NUM_WIRES) + ADDR_W'(chan_q);
      end
      S_RDW: begin
        upd_cnt_q <= cnt_n;
        upd_sum_q <= sum_n;
        if (mode_q != MODE_ADD) begin
          res_q <= (correct_en_q && !measure_q) ? corr : sample_q;
          err_q <= 1'b0;
        end
      end
      S_DIV: begin
        if (div_done) begin
          res_q <= div_quot;
          err_q <= 1'b0;
        end
      end
      default: ;
    endcase
    if (out_load) begin
      out_value_q <= res_q;
      out_err_q   <= err_q;
    end
  end

  always_comb begin
    tbl_ctrl.rd  = (state_q == S_RD);
    tbl_ctrl.wr  = (state_q == S_DIV) && div_done;
    tbl_ctrl.clr = (state_q == S_CLR);
    tbl_ctrl.cup = is_cup;
    tbl_addr     = (state_q == S_CLR) ? clr_cnt_q : addr_q;
    tbl_wdata    = '{count: upd_cnt_q, sum: upd_sum_q, offset: div_quot};
  end

  cbas_table #(
    .GRID_DEPTH (GRID_DEPTH),
    .CUP_DEPTH  (CUP_DEPTH),
    .ADDR_W     (ADDR_W)
  ) u_table (
    .clk_i   (clk_i),
    .ctrl_i  (tbl_ctrl),
    .addr_i  (tbl_addr),
    .wdata_i (tbl_wdata),
    .rdata_o (tbl_rdata)
  );

  cbas_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (state_q == S_UPD),
    .sum_i   (upd_sum_q),
    .count_i (upd_cnt_q),
    .done_o  (div_done),
    .quot_o  (div_quot)
  );

  assign out_valid_o    = out_valid_q;
  assign result_value_o = out_value_q;
  assign index_error_o  = out_err_q;

  `CBAS_ASSERT_IMP(a_div_done_in_div, div_done, state_q == S_DIV,
                   "divider finished outside the divide state")
  `CBAS_ASSERT_IMP(a_write_nonzero_count, tbl_ctrl.wr, tbl_wdata.count != '0,
                   "table write with zero sample count")
  `CBAS_ASSERT_IMP(a_out_from_out_state, $rose(out_valid_q), $past(state_q == S_OUT),
                   "result appeared without passing the output state")

endmodule

`default_nettype wire
